// ===== rtl/rwu_pkg.sv =====
// -----------------------------------------------------------------------------
// RMSProp weight update package
// Shared widths, register codes, reset values and payload types.
// -----------------------------------------------------------------------------
`default_nettype none

package rwu_pkg;

   localparam int IDX_W      = 12;
   localparam int DATA_W     = 32;
   localparam int HIST_DEPTH = 4096;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);

   localparam int RHO_W   = 16;
   localparam int DELTA_W = 16;
   localparam int LR_W    = 24;

   localparam int MAG_W      = DATA_W;
   localparam int GSQ_W      = 2 * MAG_W - 1 - 16;
   localparam int SUM_W      = DATA_W + 1;
   localparam int RAD_W      = 50;
   localparam int ROOT_W     = RAD_W / 2;
   localparam int SQRT_REM_W = ROOT_W + 3;
   localparam int NUM_W      = LR_W + MAG_W;
   localparam int DEN_W      = ROOT_W + 8;

   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   localparam logic [1:0] CSR_DECAY = 2'd0;
   localparam logic [1:0] CSR_DELTA = 2'd1;
   localparam logic [1:0] CSR_LR    = 2'd2;

   localparam logic [RHO_W-1:0]   DECAY_RESET = RHO_W'(58982);
   localparam logic [DELTA_W-1:0] DELTA_RESET = DELTA_W'(1);
   localparam logic [LR_W-1:0]    LR_RESET    = LR_W'(16777);

   localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

   typedef struct packed {
      logic [IDX_W-1:0]         element_index;
      logic signed [DATA_W-1:0] gradient;
      logic signed [DATA_W-1:0] weight;
      logic                     fresh;
      logic                     last;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_index;
      logic signed [DATA_W-1:0] new_weight;
      logic                     saturated;
      logic                     out_last;
   } rsp_type;

   typedef struct packed {
      logic [IDX_W-1:0]         out_index;
      logic signed [DATA_W-1:0] weight;
      logic                     neg;
      logic [MAG_W-1:0]         mag;
      logic                     sat;
      logic                     last;
      logic                     zero_root;
      logic                     skip;
   } ctx_type;

endpackage

`default_nettype wire

// ===== rtl/rwu_history.sv =====
// -----------------------------------------------------------------------------
// RMSProp history stage
// Squared-gradient history store with read-modify-write and clearing pass.
// -----------------------------------------------------------------------------
`default_nettype none

module rwu_history import rwu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire req_type           in_data,
   input  wire logic [RHO_W-1:0]  rho,
   output logic                   busy,
   output logic                   out_valid,
   output ctx_type                out_ctx,
   output logic [DATA_W-1:0]      out_hn
);

   logic [DATA_W-1:0] mem [HIST_DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;

   logic              s1_valid_ff;
   req_type           s1_ff;
   logic              s2_valid_ff;
   ctx_type           s2_ctx_ff;
   logic [GSQ_W-1:0]  s2_gsq_ff;
   logic [ADDR_W-1:0] s2_addr_ff;
   logic              s2_fresh_ff;
   logic              byp_ff;
   logic [DATA_W-1:0] last_hn_ff;
   logic              s3_valid_ff;
   ctx_type           s3_ctx_ff;
   logic [DATA_W-1:0] s3_hn_ff;

   logic [ADDR_W-1:0]      s1_addr;
   logic [MAG_W-1:0]       s1_mag;
   logic [2*MAG_W-1:0]     s1_sq;
   logic [DATA_W-1:0]      h;
   logic [RHO_W:0]         one_minus;
   logic [63:0]            acc;
   logic [63-16:0]         hn_full;
   logic                   hn_clip;
   logic [DATA_W-1:0]      hn;
   ctx_type                s3_ctx_in;

   always_comb begin
      s1_addr   = s1_ff.element_index[ADDR_W-1:0];
      s1_mag    = s1_ff.gradient[DATA_W-1] ? MAG_W'(~s1_ff.gradient + 1'b1)
                                           : MAG_W'(s1_ff.gradient);
      s1_sq     = s1_mag * s1_mag;
      h         = s2_fresh_ff ? '0 : (byp_ff ? last_hn_ff : rdata_ff);
      one_minus = (RHO_W+1)'(1 << RHO_W) - {1'b0, rho};
      acc       = 64'(h) * 64'(rho) + 64'(s2_gsq_ff) * 64'(one_minus);
      hn_full   = acc[63:16];
      hn_clip   = (hn_full[63-16:DATA_W] != '0);
      hn        = hn_clip ? '1 : hn_full[DATA_W-1:0];
      s3_ctx_in     = s2_ctx_ff;
      s3_ctx_in.sat = hn_clip;
   end

   // clearing pass and pipeline valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(HIST_DEPTH - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         if (en) begin
            s1_valid_ff <= in_valid;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            byp_ff      <= s2_valid_ff && s1_valid_ff && (s1_addr == s2_addr_ff);
         end
      end
   end

   // history store
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (en && s2_valid_ff) begin
         mem[s2_addr_ff] <= hn;
      end
      if (en) begin
         rdata_ff <= mem[s1_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= in_data;

         s2_ctx_ff.out_index <= s1_ff.element_index;
         s2_ctx_ff.weight    <= s1_ff.weight;
         s2_ctx_ff.neg       <= s1_ff.gradient[DATA_W-1];
         s2_ctx_ff.mag       <= s1_mag;
         s2_ctx_ff.sat       <= 1'b0;
         s2_ctx_ff.last      <= s1_ff.last;
         s2_ctx_ff.zero_root <= 1'b0;
         s2_ctx_ff.skip      <= 1'b0;
         s2_gsq_ff           <= s1_sq[GSQ_W+16-1:16];
         s2_addr_ff          <= s1_addr;
         s2_fresh_ff         <= s1_ff.fresh;

         if (s2_valid_ff) begin
            last_hn_ff <= hn;
         end

         s3_ctx_ff <= s3_ctx_in;
         s3_hn_ff  <= hn;
      end
   end

   assign busy      = clr_busy_ff;
   assign out_valid = s3_valid_ff;
   assign out_ctx   = s3_ctx_ff;
   assign out_hn    = s3_hn_ff;

endmodule

`default_nettype wire

// ===== rtl/rwu_sqrt.sv =====
// -----------------------------------------------------------------------------
// RMSProp square root
// Pipelined integer square root, one root bit per stage, floor result.
// -----------------------------------------------------------------------------
`default_nettype none

module rwu_sqrt import rwu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [RAD_W-1:0]  in_rad,
   input  wire ctx_type           in_ctx,
   output logic                   out_valid,
   output logic [ROOT_W-1:0]      out_root,
   output ctx_type                out_ctx
);

   logic                  valid_ff [ROOT_W];
   logic [SQRT_REM_W-1:0] rem_ff   [ROOT_W];
   logic [ROOT_W-1:0]     root_ff  [ROOT_W];
   logic [RAD_W-1:0]      rad_ff   [ROOT_W];
   ctx_type               ctx_ff   [ROOT_W];

   logic [SQRT_REM_W-1:0] rem_src  [ROOT_W];
   logic [ROOT_W-1:0]     root_src [ROOT_W];
   logic [RAD_W-1:0]      rad_src  [ROOT_W];
   logic [SQRT_REM_W-1:0] rem_sh   [ROOT_W];
   logic [SQRT_REM_W-1:0] trial    [ROOT_W];
   logic [SQRT_REM_W-1:0] rem_in   [ROOT_W];
   logic [ROOT_W-1:0]     root_in  [ROOT_W];
   logic [RAD_W-1:0]      rad_in   [ROOT_W];

   always_comb begin
      rem_src[0]  = '0;
      root_src[0] = '0;
      rad_src[0]  = in_rad;
      for (int k = 1; k < ROOT_W; k++) begin
         rem_src[k]  = rem_ff[k-1];
         root_src[k] = root_ff[k-1];
         rad_src[k]  = rad_ff[k-1];
      end
      for (int k = 0; k < ROOT_W; k++) begin
         rem_sh[k] = {rem_src[k][SQRT_REM_W-3:0], rad_src[k][RAD_W-1 -: 2]};
         trial[k]  = {1'b0, root_src[k], 2'b01};
         if (rem_sh[k] >= trial[k]) begin
            rem_in[k]  = rem_sh[k] - trial[k];
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = rem_sh[k];
            root_in[k] = {root_src[k][ROOT_W-2:0], 1'b0};
         end
         rad_in[k] = {rad_src[k][RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ROOT_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < ROOT_W; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0] <= in_ctx;
         for (int k = 1; k < ROOT_W; k++) begin
            ctx_ff[k] <= ctx_ff[k-1];
         end
         for (int k = 0; k < ROOT_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign out_valid = valid_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_ctx   = ctx_ff[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/rwu_div.sv =====
// -----------------------------------------------------------------------------
// RMSProp step divider
// Pipelined restoring unsigned division, one quotient bit per stage.
// -----------------------------------------------------------------------------
`default_nettype none

module rwu_div import rwu_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [NUM_W-1:0]  in_num,
   input  wire logic [DEN_W-1:0]  in_den,
   input  wire ctx_type           in_ctx,
   output logic                   out_valid,
   output logic [NUM_W-1:0]       out_quo,
   output ctx_type                out_ctx
);

   logic             valid_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff   [NUM_W];
   logic [NUM_W-1:0] quo_ff   [NUM_W];
   logic [NUM_W-1:0] num_ff   [NUM_W];
   logic [DEN_W-1:0] den_ff   [NUM_W];
   ctx_type          ctx_ff   [NUM_W];

   logic [DEN_W-1:0] rem_src [NUM_W];
   logic [NUM_W-1:0] quo_src [NUM_W];
   logic [NUM_W-1:0] num_src [NUM_W];
   logic [DEN_W-1:0] den_src [NUM_W];
   logic [DEN_W:0]   rem_sh  [NUM_W];
   logic [DEN_W:0]   diff    [NUM_W];
   logic [DEN_W-1:0] rem_in  [NUM_W];
   logic [NUM_W-1:0] quo_in  [NUM_W];

   always_comb begin
      rem_src[0] = '0;
      quo_src[0] = '0;
      num_src[0] = in_num;
      den_src[0] = in_den;
      for (int k = 1; k < NUM_W; k++) begin
         rem_src[k] = rem_ff[k-1];
         quo_src[k] = quo_ff[k-1];
         num_src[k] = num_ff[k-1];
         den_src[k] = den_ff[k-1];
      end
      for (int k = 0; k < NUM_W; k++) begin
         rem_sh[k] = {rem_src[k], num_src[k][NUM_W-1]};
         diff[k]   = rem_sh[k] - {1'b0, den_src[k]};
         if (rem_sh[k] >= {1'b0, den_src[k]}) begin
            rem_in[k] = diff[k][DEN_W-1:0];
            quo_in[k] = {quo_src[k][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[k] = rem_sh[k][DEN_W-1:0];
            quo_in[k] = {quo_src[k][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_W; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in_valid;
         for (int k = 1; k < NUM_W; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx_ff[0] <= in_ctx;
         num_ff[0] <= {in_num[NUM_W-2:0], 1'b0};
         den_ff[0] <= in_den;
         for (int k = 1; k < NUM_W; k++) begin
            ctx_ff[k] <= ctx_ff[k-1];
            num_ff[k] <= {num_ff[k-1][NUM_W-2:0], 1'b0};
            den_ff[k] <= den_ff[k-1];
         end
         for (int k = 0; k < NUM_W; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_ctx   = ctx_ff[NUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/rmsprop_weight_update.sv =====
// -----------------------------------------------------------------------------
// RMSProp weight update
// Streams weight elements, keeps squared-gradient history, returns new weights.
// -----------------------------------------------------------------------------
// The block takes one request per clock cycle while its output buffer is not
// full and returns one result per request, in order, through three history
// stages (the history read-modify-write closes in a single stage, with
// forwarding for back-to-back hits on one element), a 25-stage square root,
// one multiply stage, a 56-stage divider and a two-entry output buffer that
// keeps requests flowing while one result waits. After reset the history
// store is cleared one entry per cycle, all 4096 entries, during which no
// request is accepted; register writes are taken at any time.
`default_nettype none

module rmsprop_weight_update import rwu_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [CSR_AW-1:0]  csr_paddr,
   input  wire logic [CSR_DW-1:0]  csr_pwdata,
   output logic [CSR_DW-1:0]       csr_prdata,
   output logic                    csr_pready
);

   logic [RHO_W-1:0]   decay_ff;
   logic [DELTA_W-1:0] delta_ff;
   logic [LR_W-1:0]    lr_ff;

   logic [1:0] csr_idx;
   logic       csr_wr;

   logic en;
   logic busy;
   logic accept;

   logic              hist_valid;
   ctx_type           hist_ctx;
   logic [DATA_W-1:0] hist_hn;
   logic [RAD_W-1:0]  rad;

   logic              sq_valid;
   logic [ROOT_W-1:0] sq_root;
   ctx_type           sq_ctx;

   logic              mul_valid_ff;
   logic [NUM_W-1:0]  mul_num_ff;
   logic [DEN_W-1:0]  mul_den_ff;
   ctx_type           mul_ctx_ff;
   ctx_type           mul_ctx_in;

   logic              div_valid;
   logic [NUM_W-1:0]  div_quo;
   ctx_type           div_ctx;

   logic signed [63:0] wide;
   logic               too_hi;
   logic               too_lo;
   rsp_type            result;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       push;
   logic       pop;

   // configuration port
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff <= DECAY_RESET;
         delta_ff <= DELTA_RESET;
         lr_ff    <= LR_RESET;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_DECAY: decay_ff <= csr_pwdata[RHO_W-1:0];
            CSR_DELTA: delta_ff <= csr_pwdata[DELTA_W-1:0];
            CSR_LR:    lr_ff    <= csr_pwdata[LR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_DECAY: csr_prdata = CSR_DW'(decay_ff);
         CSR_DELTA: csr_prdata = CSR_DW'(delta_ff);
         CSR_LR:    csr_prdata = CSR_DW'(lr_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // pipeline advance
   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en && !busy;
   assign accept    = req_valid && req_ready;

   rwu_history u_history (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (accept),
      .in_data   (req_data),
      .rho       (decay_ff),
      .busy      (busy),
      .out_valid (hist_valid),
      .out_ctx   (hist_ctx),
      .out_hn    (hist_hn)
   );

   assign rad = RAD_W'({(SUM_W)'(hist_hn) + (SUM_W)'(delta_ff), 16'b0});

   rwu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (hist_valid),
      .in_rad    (rad),
      .in_ctx    (hist_ctx),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_ctx   (sq_ctx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (en) begin
         mul_valid_ff <= sq_valid;
      end
   end

   always_comb begin
      mul_ctx_in           = sq_ctx;
      mul_ctx_in.zero_root = (sq_root == '0);
      mul_ctx_in.skip      = (sq_ctx.mag == '0) || (lr_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mul_num_ff <= NUM_W'(lr_ff) * NUM_W'(sq_ctx.mag);
         mul_den_ff <= {sq_root, 8'b0};
         mul_ctx_ff <= mul_ctx_in;
      end
   end

   rwu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (mul_valid_ff),
      .in_num    (mul_num_ff),
      .in_den    (mul_den_ff),
      .in_ctx    (mul_ctx_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_ctx   (div_ctx)
   );

   // apply step and clip
   always_comb begin
      wide   = div_ctx.neg ? 64'(div_ctx.weight) + $signed(64'(div_quo))
                           : 64'(div_ctx.weight) - $signed(64'(div_quo));
      too_hi = !wide[63] && (wide[62:DATA_W-1] != '0);
      too_lo = wide[63] && (wide[62:DATA_W-1] != '1);

      result.out_index = div_ctx.out_index;
      result.out_last  = div_ctx.last;
      priority if (div_ctx.skip) begin
         result.new_weight = div_ctx.weight;
         result.saturated  = div_ctx.sat;
      end else if (div_ctx.zero_root) begin
         result.new_weight = div_ctx.neg ? SMAX : SMIN;
         result.saturated  = 1'b1;
      end else if (too_hi) begin
         result.new_weight = SMAX;
         result.saturated  = 1'b1;
      end else if (too_lo) begin
         result.new_weight = SMIN;
         result.saturated  = 1'b1;
      end else begin
         result.new_weight = wide[DATA_W-1:0];
         result.saturated  = div_ctx.sat;
      end
   end

   // output buffer
   assign push      = en && div_valid;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= result;
      end
   end

endmodule

`default_nettype wire
